FILE: design/ddpi_pkg.sv
`timescale 1ns / 1ps

package ddpi_pkg;

	// Default sizes handed to the top level parameters.
	localparam int NUM_ROBOTS_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN        = 3'd0,
		CFG_INTEGRAL_GAIN    = 3'd1,
		CFG_INV_WHEEL_RADIUS = 3'd2,
		CFG_AXLE_LENGTH      = 3'd3,
		CFG_INTEGRAL_LIMIT   = 3'd4,
		CFG_TORQUE_LIMIT     = 3'd5
	} cfg_idx_t;

	// Values the registers take at reset.
	localparam logic [15:0] PROP_GAIN_RST        = 16'd10240;
	localparam logic [15:0] INTEGRAL_GAIN_RST    = 16'd2048;
	localparam logic [15:0] INV_WHEEL_RADIUS_RST = 16'd40960;
	localparam logic [15:0] AXLE_LENGTH_RST      = 16'd819;
	localparam logic [22:0] INTEGRAL_LIMIT_RST   = 23'd256000;
	localparam logic [22:0] TORQUE_LIMIT_RST     = 23'd2560;

	// Live configuration as seen by the datapath.
	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] integral_gain;
		logic [15:0] inv_wheel_radius;
		logic [15:0] axle_length;
		logic [22:0] integral_limit;
		logic [22:0] torque_limit;
	} cfg_t;

	// One controller step request.
	typedef struct packed {
		logic [2:0]         robot_index;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] heading_cos;
		logic signed [15:0] heading_sin;
		logic signed [15:0] yaw_rate;
		logic signed [15:0] target_speed;
		logic signed [15:0] target_turn;
	} item_t;

	// Classified request as it waits in the queue.
	typedef struct packed {
		logic  in_range;
		item_t item;
	} cmd_t;

	// One controller step result.
	typedef struct packed {
		logic signed [23:0] left_torque;
		logic signed [23:0] right_torque;
		logic signed [23:0] left_force_x;
		logic signed [23:0] left_force_y;
		logic signed [23:0] right_force_x;
		logic signed [23:0] right_force_y;
	} result_t;

endpackage

FILE: design/ddpi_if.sv
`timescale 1ns / 1ps

// Request channel.
interface ddpi_item_if ();
	logic             valid;
	logic             ready;
	ddpi_pkg::item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// Classified request channel between front end and back end.
interface ddpi_cmd_if ();
	logic            valid;
	logic            ready;
	ddpi_pkg::cmd_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// Result channel.
interface ddpi_result_if ();
	logic               valid;
	logic               ready;
	ddpi_pkg::result_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: design/ddpi_front.sv
`timescale 1ns / 1ps

module ddpi_front #(
	parameter int NUM_ROBOTS = ddpi_pkg::NUM_ROBOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ddpi_item_if.sink      item,
	ddpi_cmd_if.source     cmd
);

	logic            vld_q;
	ddpi_pkg::cmd_t  cmd_q;
	logic            in_range;

	// A robot index beyond the integrator store gets no state.
	assign in_range = int'(item.payload.robot_index) < NUM_ROBOTS;

	// The stage takes a new transaction whenever it is empty or being drained.
	assign item.ready  = !vld_q || cmd.ready;
	assign cmd.valid   = vld_q;
	assign cmd.payload = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (item.ready) begin
			vld_q <= item.valid;
		end
	end

	// Request payload with its classification.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_q.in_range <= in_range;
			cmd_q.item     <= item.payload;
		end
	end

endmodule

FILE: design/ddpi_fifo.sv
`timescale 1ns / 1ps

module ddpi_fifo #(
	parameter int DEPTH = ddpi_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ddpi_cmd_if.sink    wr,
	ddpi_cmd_if.source  rd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ddpi_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              push;
	logic              pop;

	assign wr.ready   = cnt_q != CNT_W'(DEPTH);
	assign rd.valid   = cnt_q != '0;
	assign rd.payload = mem_q[rd_ptr_q];
	assign push       = wr.valid && wr.ready;
	assign pop        = rd.valid && rd.ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr.payload;
		end
	end

endmodule

FILE: design/ddpi_back.sv
`timescale 1ns / 1ps

module ddpi_back #(
	parameter int NUM_ROBOTS = ddpi_pkg::NUM_ROBOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ddpi_pkg::cfg_t  cfg,
	ddpi_cmd_if.sink        cmd,
	ddpi_result_if.source   result
);

	localparam int IDX_W = (NUM_ROBOTS > 1) ? $clog2(NUM_ROBOTS) : 1;
	localparam logic signed [25:0] S24_MAX = 26'sd8388607;
	localparam logic signed [25:0] S24_MIN = -26'sd8388608;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPEED,
		ST_WHEEL,
		ST_ERROR,
		ST_INTEG,
		ST_GAIN,
		ST_TORQUE,
		ST_FORCE,
		ST_OUT
	} state_t;

	// Saturate a rounded force to the signed 24-bit range.
	function automatic logic signed [23:0] sat24(input logic signed [25:0] x);
		logic signed [25:0] y;
		if (x > S24_MAX) begin
			y = S24_MAX;
		end else if (x < S24_MIN) begin
			y = S24_MIN;
		end else begin
			y = x;
		end
		return 24'(y);
	endfunction

	// Wheel speed product back to 8 fraction bits, rounding half up.
	function automatic logic signed [25:0] rnd25(input logic signed [50:0] x);
		logic signed [50:0] t;
		t = x + 51'sd16777216;
		return t[50:25];
	endfunction

	// Force product back to 8 fraction bits, rounding half up.
	function automatic logic signed [25:0] rnd14(input logic signed [39:0] x);
		logic signed [39:0] t;
		t = x + 40'sd8192;
		return t[39:14];
	endfunction

	state_t              state_q;
	ddpi_pkg::cmd_t      cur_q;
	ddpi_pkg::result_t   res_q;
	logic                res_valid_q;

	logic signed [32:0]  dot_q;
	logic [17:0]         speed_q;
	logic signed [32:0]  tm_q;
	logic signed [32:0]  tt_q;
	logic signed [50:0]  wml_q;
	logic signed [50:0]  wmr_q;
	logic signed [50:0]  wtl_q;
	logic signed [50:0]  wtr_q;
	logic signed [26:0]  el_q;
	logic signed [26:0]  er_q;
	logic signed [23:0]  il_q;
	logic signed [23:0]  ir_q;
	logic signed [43:0]  ppl_q;
	logic signed [43:0]  ppr_q;
	logic signed [40:0]  pil_q;
	logic signed [40:0]  pir_q;
	logic signed [23:0]  tl_q;
	logic signed [23:0]  tr_q;
	logic signed [39:0]  fxl_q;
	logic signed [39:0]  fyl_q;
	logic signed [39:0]  fxr_q;
	logic signed [39:0]  fyr_q;

	logic [47:0]         integ_mem_q [NUM_ROBOTS];
	logic [NUM_ROBOTS-1:0] integ_vld_q;
	logic [47:0]         rd_q;
	logic                rd_ok_q;

	logic                take;
	logic                out_free;
	logic [IDX_W-1:0]    head_addr;
	logic [IDX_W-1:0]    cur_addr;
	logic signed [31:0]  dpx;
	logic signed [31:0]  dpy;
	logic signed [32:0]  dot_d;
	logic [31:0]         dot_abs;
	logic [17:0]         speed_d;
	logic signed [16:0]  axle17;
	logic signed [16:0]  inv17;
	logic signed [16:0]  pg17;
	logic signed [16:0]  ig17;
	logic signed [31:0]  sm;
	logic signed [28:0]  st;
	logic signed [33:0]  sum_ml;
	logic signed [33:0]  sum_mr;
	logic signed [33:0]  sum_tl;
	logic signed [33:0]  sum_tr;
	logic signed [23:0]  base_l;
	logic signed [23:0]  base_r;
	logic signed [27:0]  acc_l;
	logic signed [27:0]  acc_r;
	logic signed [27:0]  ilim_pos;
	logic signed [23:0]  il_d;
	logic signed [23:0]  ir_d;
	logic signed [44:0]  pi_l;
	logic signed [44:0]  pi_r;
	logic signed [32:0]  tq_l;
	logic signed [32:0]  tq_r;
	logic signed [32:0]  tlim_pos;
	logic signed [23:0]  tl_d;
	logic signed [23:0]  tr_d;

	// Request handshake: one step in flight at a time.
	assign cmd.ready      = state_q == ST_IDLE;
	assign take           = cmd.valid && (state_q == ST_IDLE);
	assign out_free       = !res_valid_q || result.ready;
	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	assign head_addr = IDX_W'(cmd.payload.item.robot_index);
	assign cur_addr  = IDX_W'(cur_q.item.robot_index);

	// Step one: projection of velocity onto the heading.
	assign dpx   = cmd.payload.item.vel_x * cmd.payload.item.heading_cos;
	assign dpy   = cmd.payload.item.vel_y * cmd.payload.item.heading_sin;
	assign dot_d = 33'(dpx) + 33'(dpy);

	// Step two: forward speed magnitude and the turn terms.
	assign axle17  = $signed({1'b0, cfg.axle_length});
	assign dot_abs = dot_q[32] ? 32'(-dot_q) : 32'(dot_q);
	assign speed_d = 18'((33'(dot_abs) + 33'd8192) >> 14);

	// Step three: wheel speed sums before scaling by the inverse radius.
	assign inv17  = $signed({1'b0, cfg.inv_wheel_radius});
	assign sm     = $signed({1'b0, speed_q, 13'b0});
	assign st     = $signed({cur_q.item.target_speed, 13'b0});
	assign sum_ml = 34'(sm) - 34'(tm_q);
	assign sum_mr = 34'(sm) + 34'(tm_q);
	assign sum_tl = 34'(st) - 34'(tt_q);
	assign sum_tr = 34'(st) + 34'(tt_q);

	// Step five: integrators with saturation; a missing entry reads as zero.
	assign ilim_pos = $signed({5'b0, cfg.integral_limit});
	assign base_l   = rd_ok_q ? $signed(rd_q[47:24]) : '0;
	assign base_r   = rd_ok_q ? $signed(rd_q[23:0]) : '0;
	assign acc_l    = 28'(base_l) + 28'(el_q);
	assign acc_r    = 28'(base_r) + 28'(er_q);

	always_comb begin
		if (acc_l > ilim_pos) begin
			il_d = 24'(ilim_pos);
		end else if (acc_l < -ilim_pos) begin
			il_d = 24'(-ilim_pos);
		end else begin
			il_d = 24'(acc_l);
		end
		if (acc_r > ilim_pos) begin
			ir_d = 24'(ilim_pos);
		end else if (acc_r < -ilim_pos) begin
			ir_d = 24'(-ilim_pos);
		end else begin
			ir_d = 24'(acc_r);
		end
	end

	// Step six gains; step seven rounds and saturates the torques.
	assign pg17     = $signed({1'b0, cfg.prop_gain});
	assign ig17     = $signed({1'b0, cfg.integral_gain});
	assign tlim_pos = $signed({10'b0, cfg.torque_limit});
	assign pi_l     = 45'(ppl_q) + 45'(pil_q) + 45'sd2048;
	assign pi_r     = 45'(ppr_q) + 45'(pir_q) + 45'sd2048;
	assign tq_l     = pi_l[44:12];
	assign tq_r     = pi_r[44:12];

	always_comb begin
		if (tq_l > tlim_pos) begin
			tl_d = 24'(tlim_pos);
		end else if (tq_l < -tlim_pos) begin
			tl_d = 24'(-tlim_pos);
		end else begin
			tl_d = 24'(tq_l);
		end
		if (tq_r > tlim_pos) begin
			tr_d = 24'(tlim_pos);
		end else if (tq_r < -tlim_pos) begin
			tr_d = 24'(-tlim_pos);
		end else begin
			tr_d = 24'(tq_r);
		end
	end

	// Sequencer state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// A taken result empties the register unless the next one replaces it.
			if (res_valid_q && result.ready && state_q != ST_OUT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_SPEED;
					end
				end
				ST_SPEED:  state_q <= ST_WHEEL;
				ST_WHEEL:  state_q <= ST_ERROR;
				ST_ERROR:  state_q <= ST_INTEG;
				ST_INTEG:  state_q <= ST_GAIN;
				ST_GAIN:   state_q <= ST_TORQUE;
				ST_TORQUE: state_q <= ST_FORCE;
				ST_FORCE:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						res_q.left_torque   <= tl_q;
						res_q.right_torque  <= tr_q;
						res_q.left_force_x  <= sat24(rnd14(fxl_q));
						res_q.left_force_y  <= sat24(rnd14(fyl_q));
						res_q.right_force_x <= sat24(rnd14(fxr_q));
						res_q.right_force_y <= sat24(rnd14(fyr_q));
						res_valid_q         <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Working registers of the step in flight.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					cur_q <= cmd.payload;
					dot_q <= dot_d;
				end
			end
			ST_SPEED: begin
				speed_q <= speed_d;
				tm_q    <= cur_q.item.yaw_rate * axle17;
				tt_q    <= cur_q.item.target_turn * axle17;
			end
			ST_WHEEL: begin
				wml_q <= sum_ml * inv17;
				wmr_q <= sum_mr * inv17;
				wtl_q <= sum_tl * inv17;
				wtr_q <= sum_tr * inv17;
			end
			ST_ERROR: begin
				el_q <= 27'(rnd25(wtl_q)) - 27'(rnd25(wml_q));
				er_q <= 27'(rnd25(wtr_q)) - 27'(rnd25(wmr_q));
			end
			ST_INTEG: begin
				il_q <= il_d;
				ir_q <= ir_d;
			end
			ST_GAIN: begin
				ppl_q <= el_q * pg17;
				ppr_q <= er_q * pg17;
				pil_q <= il_q * ig17;
				pir_q <= ir_q * ig17;
			end
			ST_TORQUE: begin
				tl_q <= tl_d;
				tr_q <= tr_d;
			end
			ST_FORCE: begin
				fxl_q <= tl_q * cur_q.item.heading_cos;
				fyl_q <= tl_q * cur_q.item.heading_sin;
				fxr_q <= tr_q * cur_q.item.heading_cos;
				fyr_q <= tr_q * cur_q.item.heading_sin;
			end
			ST_OUT: begin
			end
		endcase
	end

	// Integrator store: read when a step starts, written back after saturation.
	always_ff @(posedge clk) begin
		if (take) begin
			rd_q    <= integ_mem_q[head_addr];
			rd_ok_q <= cmd.payload.in_range && integ_vld_q[head_addr];
		end
		if (state_q == ST_INTEG && cur_q.in_range) begin
			integ_mem_q[cur_addr] <= {il_d, ir_d};
		end
	end

	// Entry valid bits; an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_vld_q <= '0;
		end else if (state_q == ST_INTEG && cur_q.in_range) begin
			integ_vld_q[cur_addr] <= 1'b1;
		end
	end

endmodule

FILE: design/diff_drive_wheel_pi_controller_top.sv
`timescale 1ns / 1ps

// Wheel PI controller for differential-drive robots with integrator anti-windup.
// The item channel carries one control step for one robot: measured velocity,
// heading cosine and sine, yaw rate and the target forward speed and turn rate.
// The result channel returns both saturated wheel torques and their force
// vectors along the heading. Both channels move a transaction on a clock edge
// with valid and ready high.
// An accepted request passes the input register, the queue and the back-end
// sequencer states SPEED to OUT; the sequencer works on one transaction at a
// time and takes no new one until its result is in the output register.
// An input register and a queue of QUEUE_DEPTH entries let up to QUEUE_DEPTH + 1
// further transactions be accepted while a step is being computed.
// When the receiver stalls, the finished result waits in the output register
// and the next step runs up to its last cycle before it waits as well.
// Reset clears all integrators to zero, loads the register defaults and empties
// the queue. The user must write registers through cfg_we, cfg_index and
// cfg_wdata only while no step is outstanding; the block does not enforce it.
module diff_drive_wheel_pi_controller_top #(
	parameter int NUM_ROBOTS  = ddpi_pkg::NUM_ROBOTS_DEF,
	parameter int QUEUE_DEPTH = ddpi_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ddpi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ddpi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	ddpi_item_if.sink                         item,
	ddpi_result_if.source                     result
);

	ddpi_pkg::cfg_t  cfg_q;

	ddpi_cmd_if q_in ();
	ddpi_cmd_if q_out ();

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain        <= ddpi_pkg::PROP_GAIN_RST;
			cfg_q.integral_gain    <= ddpi_pkg::INTEGRAL_GAIN_RST;
			cfg_q.inv_wheel_radius <= ddpi_pkg::INV_WHEEL_RADIUS_RST;
			cfg_q.axle_length      <= ddpi_pkg::AXLE_LENGTH_RST;
			cfg_q.integral_limit   <= ddpi_pkg::INTEGRAL_LIMIT_RST;
			cfg_q.torque_limit     <= ddpi_pkg::TORQUE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ddpi_pkg::CFG_PROP_GAIN:        cfg_q.prop_gain        <= cfg_wdata[15:0];
				ddpi_pkg::CFG_INTEGRAL_GAIN:    cfg_q.integral_gain    <= cfg_wdata[15:0];
				ddpi_pkg::CFG_INV_WHEEL_RADIUS: cfg_q.inv_wheel_radius <= cfg_wdata[15:0];
				ddpi_pkg::CFG_AXLE_LENGTH:      cfg_q.axle_length      <= cfg_wdata[15:0];
				ddpi_pkg::CFG_INTEGRAL_LIMIT:   cfg_q.integral_limit   <= cfg_wdata;
				ddpi_pkg::CFG_TORQUE_LIMIT:     cfg_q.torque_limit     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Front end: accepts and classifies requests.
	ddpi_front #(
		.NUM_ROBOTS (NUM_ROBOTS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (q_in)
	);

	// Queue between front and back end.
	ddpi_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_in),
		.rd     (q_out)
	);

	// Back end: controller arithmetic and integrator store.
	ddpi_back #(
		.NUM_ROBOTS (NUM_ROBOTS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (q_out),
		.result (result)
	);

endmodule

FILE: design/ddpi_checker.sv
`timescale 1ns / 1ps

module ddpi_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ddpi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ddpi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             result_valid,
	input  logic                             result_ready,
	input  logic signed [23:0]               left_torque,
	input  logic signed [23:0]               right_torque,
	input  logic signed [23:0]               left_force_x,
	input  logic signed [23:0]               left_force_y,
	input  logic signed [23:0]               right_force_x,
	input  logic signed [23:0]               right_force_y
);

	logic [22:0]         tlim_q;
	logic signed [24:0]  lim_pos;

	// Shadow of the torque limit as written on the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlim_q <= ddpi_pkg::TORQUE_LIMIT_RST;
		end else if (cfg_we && cfg_index == ddpi_pkg::CFG_TORQUE_LIMIT) begin
			tlim_q <= cfg_wdata;
		end
	end

	assign lim_pos = $signed({2'b0, tlim_q});

	// A result that is not taken stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result withdrawn before the transaction completed");

	// Torques never leave the programmed limit.
	a_left_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (25'(left_torque) <= lim_pos) && (25'(left_torque) >= -lim_pos))
		else $error("left torque outside the torque limit");

	a_right_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (25'(right_torque) <= lim_pos) && (25'(right_torque) >= -lim_pos))
		else $error("right torque outside the torque limit");

	// A wheel without drive produces no force.
	a_zero_force: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
		(left_torque != 24'sd0 || (left_force_x == 24'sd0 && left_force_y == 24'sd0)) &&
		(right_torque != 24'sd0 || (right_force_x == 24'sd0 && right_force_y == 24'sd0)))
		else $error("force reported for a zero torque");

endmodule

bind diff_drive_wheel_pi_controller_top ddpi_checker u_ddpi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.cfg_index     (cfg_index),
	.cfg_wdata     (cfg_wdata),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.left_torque   (result.payload.left_torque),
	.right_torque  (result.payload.right_torque),
	.left_force_x  (result.payload.left_force_x),
	.left_force_y  (result.payload.left_force_y),
	.right_force_x (result.payload.right_force_x),
	.right_force_y (result.payload.right_force_y)
);
